@@ rtl/core/mafd_pkg.sv @@
// Package for the meter answer frame decoder: transaction types, frame
// constants, code values and the digit decode function. No dependencies.
`default_nettype none

package mafd_pkg;

    localparam int unsigned FRAME_LEN = 12;
    localparam int unsigned POS_W     = 4;

    localparam logic [POS_W-1:0] POS_HEADER  = 4'd0;
    localparam logic [POS_W-1:0] POS_FUNC    = 4'd1;
    localparam logic [POS_W-1:0] POS_RANGE   = 4'd2;
    localparam logic [POS_W-1:0] POS_SIGN    = 4'd4;
    localparam logic [POS_W-1:0] POS_DIG_A   = 4'd5;
    localparam logic [POS_W-1:0] POS_DIG_B   = 4'd6;
    localparam logic [POS_W-1:0] POS_DIG_C   = 4'd7;
    localparam logic [POS_W-1:0] POS_DIG_D   = 4'd8;
    localparam logic [POS_W-1:0] POS_DIG_E   = 4'd9;
    localparam logic [POS_W-1:0] POS_TRAILER = 4'd11;

    localparam logic [7:0] HEADER_BYTE   = 8'h89;
    localparam logic [7:0] TRAILER_BYTE  = 8'h0a;
    localparam logic [7:0] OVERLOAD_BYTE = 8'h3e;
    localparam logic [7:0] ZERO_BYTE     = 8'h30;
    localparam logic [7:0] NINE_BYTE     = 8'h39;
    localparam int unsigned SIGN_BIT     = 4;

    // function field of byte 1
    localparam logic [3:0] FF_GEN   = 4'h4;
    localparam logic [3:0] FF_AMP   = 4'h5;
    localparam logic [3:0] FF_MAMP  = 4'h6;
    localparam logic [3:0] FF_TEMP  = 4'h8;
    localparam logic [3:0] FF_CAP   = 4'h9;
    localparam logic [3:0] FF_FREQ  = 4'ha;
    localparam logic [3:0] FF_DIODE = 4'hb;
    localparam logic [3:0] FF_OHM   = 4'hc;
    localparam logic [3:0] FF_MV    = 4'hd;
    localparam logic [3:0] FF_DCV   = 4'he;
    localparam logic [3:0] FF_ACV   = 4'hf;

    // reported function codes
    localparam logic [3:0] FN_GEN     = 4'd0;
    localparam logic [3:0] FN_AMP     = 4'd1;
    localparam logic [3:0] FN_MAMP    = 4'd2;
    localparam logic [3:0] FN_TEMP    = 4'd3;
    localparam logic [3:0] FN_CAP     = 4'd4;
    localparam logic [3:0] FN_FREQ    = 4'd5;
    localparam logic [3:0] FN_DIODE   = 4'd6;
    localparam logic [3:0] FN_OHM     = 4'd7;
    localparam logic [3:0] FN_MV      = 4'd8;
    localparam logic [3:0] FN_DCV     = 4'd9;
    localparam logic [3:0] FN_ACV     = 4'd10;
    localparam logic [3:0] FN_UNKNOWN = 4'd11;

    localparam logic [2:0] UNIT_NONE       = 3'd0;
    localparam logic [2:0] UNIT_AMPERE     = 3'd1;
    localparam logic [2:0] UNIT_DEGC       = 3'd2;
    localparam logic [2:0] UNIT_FARAD      = 3'd3;
    localparam logic [2:0] UNIT_HERTZ      = 3'd4;
    localparam logic [2:0] UNIT_VOLT       = 3'd5;
    localparam logic [2:0] UNIT_RESISTANCE = 3'd6;

    localparam logic [2:0] PFX_NONE  = 3'd0;
    localparam logic [2:0] PFX_MILLI = 3'd1;
    localparam logic [2:0] PFX_NANO  = 3'd2;
    localparam logic [2:0] PFX_MICRO = 3'd3;
    localparam logic [2:0] PFX_MEGA  = 3'd4;
    localparam logic [2:0] PFX_KILO  = 3'd5;

    localparam logic [3:0] DIG_OVERLOAD = 4'd10;
    localparam logic [3:0] DIG_BLANK    = 4'd11;

    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_BAD = 1'b1;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       frame_start;
    } t_in_data;

    typedef struct packed {
        logic       status;
        logic [3:0] func_code;
        logic [2:0] unit_code;
        logic [2:0] prefix_code;
        logic [3:0] point_pos;
        logic       negative;
        logic [3:0] digit_a;
        logic [3:0] digit_b;
        logic [3:0] digit_c;
        logic [3:0] digit_d;
        logic [3:0] digit_e;
    } t_out_data;

    // function/range decode result
    typedef struct packed {
        logic [3:0] func_code;
        logic [2:0] unit_code;
        logic [2:0] prefix_code;
        logic [3:0] point_pos;
    } t_meas;

    function automatic logic [3:0] digit_code(input logic [7:0] b);
        logic [7:0] diff;
        diff = b - ZERO_BYTE;
        if (b >= ZERO_BYTE && b <= NINE_BYTE) begin
            digit_code = diff[3:0];
        end else if (b == OVERLOAD_BYTE) begin
            digit_code = DIG_OVERLOAD;
        end else begin
            digit_code = DIG_BLANK;
        end
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/mafd_decode.sv @@
// Function and range decode: maps the stored function and range fields to
// function, unit, prefix and decimal point codes. Uses mafd_pkg.
`default_nettype none

module mafd_decode (
    input  wire logic [3:0]      i_function_field,
    input  wire logic [2:0]      i_range_field,
    output mafd_pkg::t_meas      o_meas
);

    logic [3:0] dp;

    assign dp = {1'b0, i_range_field} + 4'd1;

    always_comb begin
        o_meas.func_code   = mafd_pkg::FN_UNKNOWN;
        o_meas.unit_code   = mafd_pkg::UNIT_NONE;
        o_meas.prefix_code = mafd_pkg::PFX_NONE;
        o_meas.point_pos   = dp;
        case (i_function_field)
            mafd_pkg::FF_GEN: begin
                o_meas.func_code = mafd_pkg::FN_GEN;
            end
            mafd_pkg::FF_AMP: begin
                o_meas.func_code = mafd_pkg::FN_AMP;
                o_meas.unit_code = mafd_pkg::UNIT_AMPERE;
                o_meas.point_pos = dp - 4'd1;
            end
            mafd_pkg::FF_MAMP: begin
                o_meas.func_code   = mafd_pkg::FN_MAMP;
                o_meas.unit_code   = mafd_pkg::UNIT_AMPERE;
                o_meas.prefix_code = mafd_pkg::PFX_MILLI;
            end
            mafd_pkg::FF_TEMP: begin
                o_meas.func_code = mafd_pkg::FN_TEMP;
                o_meas.unit_code = mafd_pkg::UNIT_DEGC;
            end
            mafd_pkg::FF_CAP: begin
                o_meas.func_code = mafd_pkg::FN_CAP;
                o_meas.unit_code = mafd_pkg::UNIT_FARAD;
                if (dp < 4'd4) begin
                    o_meas.prefix_code = mafd_pkg::PFX_NANO;
                    o_meas.point_pos   = dp - 4'd1;
                end else begin
                    o_meas.prefix_code = mafd_pkg::PFX_MICRO;
                    o_meas.point_pos   = dp - 4'd4;
                end
            end
            mafd_pkg::FF_FREQ: begin
                o_meas.func_code = mafd_pkg::FN_FREQ;
                o_meas.unit_code = mafd_pkg::UNIT_HERTZ;
            end
            mafd_pkg::FF_DIODE: begin
                o_meas.func_code = mafd_pkg::FN_DIODE;
                o_meas.unit_code = mafd_pkg::UNIT_VOLT;
                o_meas.point_pos = dp - 4'd1;
            end
            mafd_pkg::FF_OHM: begin
                o_meas.func_code = mafd_pkg::FN_OHM;
                o_meas.unit_code = mafd_pkg::UNIT_RESISTANCE;
                if (dp == 4'd1) begin
                    o_meas.point_pos = 4'd2;
                end else if (dp == 4'd5 || dp == 4'd6) begin
                    o_meas.prefix_code = mafd_pkg::PFX_MEGA;
                    o_meas.point_pos   = dp - 4'd5;
                end else begin
                    o_meas.prefix_code = mafd_pkg::PFX_KILO;
                    o_meas.point_pos   = dp - 4'd2;
                end
            end
            mafd_pkg::FF_MV: begin
                o_meas.func_code   = mafd_pkg::FN_MV;
                o_meas.unit_code   = mafd_pkg::UNIT_VOLT;
                o_meas.prefix_code = mafd_pkg::PFX_MILLI;
            end
            mafd_pkg::FF_DCV: begin
                o_meas.func_code = mafd_pkg::FN_DCV;
                o_meas.unit_code = mafd_pkg::UNIT_VOLT;
                o_meas.point_pos = dp - 4'd1;
            end
            mafd_pkg::FF_ACV: begin
                o_meas.func_code = mafd_pkg::FN_ACV;
                o_meas.unit_code = mafd_pkg::UNIT_VOLT;
                o_meas.point_pos = dp - 4'd1;
            end
            default: begin
                o_meas.func_code = mafd_pkg::FN_UNKNOWN;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ rtl/core/meter_answer_frame_decoder.sv @@
// Meter answer frame decoder top level: frame byte capture and the result
// register. Uses mafd_pkg and mafd_decode.
//
//   channel   valid         ready         payload
//   input     i_in_valid    o_in_ready    i_in_data  (t_in_data)
//   output    o_out_valid   i_out_ready   o_out_data (t_out_data)
//
// One byte per cycle. Each byte updates the frame state in the cycle it is
// taken; the twelfth byte loads the result register, visible the next cycle.
// A held result stalls input only when the output side is also stalled.
// Synchronous active-low reset clears position, flags, the stored function and range fields and the output valid.
`default_nettype none

module meter_answer_frame_decoder (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output      logic                  o_in_ready,
    input  wire mafd_pkg::t_in_data    i_in_data,
    output      logic                  o_out_valid,
    input  wire logic                  i_out_ready,
    output      mafd_pkg::t_out_data   o_out_data
);

    logic [mafd_pkg::POS_W-1:0] r_pos, n_pos;
    logic [mafd_pkg::POS_W-1:0] cur_pos;
    logic                       r_header_ok;
    logic [3:0]                 r_func_field;
    logic [2:0]                 r_range_field;
    logic                       r_sign;
    logic [3:0]                 r_dig_a, r_dig_b, r_dig_c, r_dig_d, r_dig_e;
    logic                       r_out_valid;
    mafd_pkg::t_out_data        r_out_data, n_out_data;
    mafd_pkg::t_meas            meas;
    logic                       in_fire;
    logic                       last_byte;
    logic [3:0]                 dig_code;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign in_fire    = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    always_comb begin
        if (i_in_data.frame_start || r_pos >= mafd_pkg::POS_W'(mafd_pkg::FRAME_LEN)) begin
            cur_pos = mafd_pkg::POS_HEADER;
        end else begin
            cur_pos = r_pos;
        end
    end

    assign last_byte = (cur_pos == mafd_pkg::POS_TRAILER);
    assign n_pos     = last_byte ? mafd_pkg::POS_HEADER : cur_pos + 4'd1;
    assign dig_code  = mafd_pkg::digit_code(i_in_data.rx_byte);

    mafd_decode u_decode (
        .i_function_field (r_func_field),
        .i_range_field    (r_range_field),
        .o_meas           (meas)
    );

    always_comb begin
        n_out_data = '0;
        if (!r_header_ok || i_in_data.rx_byte != mafd_pkg::TRAILER_BYTE) begin
            n_out_data.status = mafd_pkg::STATUS_BAD;
        end else begin
            n_out_data.status      = mafd_pkg::STATUS_OK;
            n_out_data.func_code   = meas.func_code;
            n_out_data.unit_code   = meas.unit_code;
            n_out_data.prefix_code = meas.prefix_code;
            n_out_data.point_pos   = meas.point_pos;
            n_out_data.negative    = r_sign;
            n_out_data.digit_a     = r_dig_a;
            n_out_data.digit_b     = r_dig_b;
            n_out_data.digit_c     = r_dig_c;
            n_out_data.digit_d     = r_dig_d;
            n_out_data.digit_e     = r_dig_e;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos         <= mafd_pkg::POS_HEADER;
            r_header_ok   <= 1'b0;
            r_func_field  <= '0;
            r_range_field <= '0;
            r_sign        <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            if (in_fire) begin
                r_pos <= n_pos;
                case (cur_pos)
                    mafd_pkg::POS_HEADER: begin
                        r_header_ok <= (i_in_data.rx_byte == mafd_pkg::HEADER_BYTE);
                    end
                    mafd_pkg::POS_FUNC: begin
                        r_func_field <= i_in_data.rx_byte[6:3];
                    end
                    mafd_pkg::POS_RANGE: begin
                        r_range_field <= i_in_data.rx_byte[5:3];
                    end
                    mafd_pkg::POS_SIGN: begin
                        r_sign <= i_in_data.rx_byte[mafd_pkg::SIGN_BIT];
                    end
                    default: begin
                    end
                endcase
            end
            if (in_fire && last_byte) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // digit store and result payload, no reset
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            case (cur_pos)
                mafd_pkg::POS_DIG_A: begin
                    r_dig_a <= dig_code;
                end
                mafd_pkg::POS_DIG_B: begin
                    r_dig_b <= dig_code;
                end
                mafd_pkg::POS_DIG_C: begin
                    r_dig_c <= dig_code;
                end
                mafd_pkg::POS_DIG_D: begin
                    r_dig_d <= dig_code;
                end
                mafd_pkg::POS_DIG_E: begin
                    r_dig_e <= dig_code;
                end
                default: begin
                end
            endcase
            if (last_byte) begin
                r_out_data <= n_out_data;
            end
        end
    end

`ifndef NO_ASSERTIONS
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= mafd_pkg::POS_TRAILER)
        else $error("byte position out of frame");

    a_start_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire && i_in_data.frame_start |=> r_pos == mafd_pkg::POS_FUNC)
        else $error("frame start did not restart the frame");

    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(in_fire && last_byte))
        else $error("result without a trailer byte transaction");

    a_bad_fields_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.status == mafd_pkg::STATUS_BAD |->
            o_out_data.func_code == '0 && o_out_data.point_pos == '0 &&
            o_out_data.digit_a == '0 && o_out_data.negative == 1'b0)
        else $error("bad frame carries nonzero fields");

    a_last_wraps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire && last_byte |=> r_pos == mafd_pkg::POS_HEADER && o_out_valid)
        else $error("trailer byte did not close the frame");
`endif

endmodule

`default_nettype wire
